>>> rtl/lbc_pkg.sv
// Shared types, widths and helper functions of the line segment clipper.
package lbc_pkg;

   localparam int COORD_BITS    = 16;
   localparam int FRACTION_BITS = 16;

   localparam int SIZE_BITS  = COORD_BITS - 1;
   localparam int EDGE_BITS  = COORD_BITS + 2;
   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int MAG_BITS   = COORD_BITS;
   localparam int REM_BITS   = COORD_BITS + 1;
   localparam int QUO_BITS   = FRACTION_BITS + 1;
   localparam int T_BITS     = FRACTION_BITS + 2;
   localparam int PROD_BITS  = T_BITS + 1 + DELTA_BITS;
   localparam int NUM_EDGES  = 4;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = COORD_BITS;

   localparam logic [T_BITS-1:0] T_ONE = T_BITS'(64'd1 << FRACTION_BITS);
   localparam logic [T_BITS-1:0] T_TWO = T_BITS'(64'd2 << FRACTION_BITS);

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_USE_WINDOW    = 3'd0,
      REG_WINDOW_LEFT   = 3'd1,
      REG_WINDOW_TOP    = 3'd2,
      REG_WINDOW_WIDTH  = 3'd3,
      REG_WINDOW_HEIGHT = 3'd4,
      REG_BUFFER_WIDTH  = 3'd5,
      REG_BUFFER_HEIGHT = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic                   use_window;
      logic [COORD_BITS-1:0]  window_left;
      logic [COORD_BITS-1:0]  window_top;
      logic [SIZE_BITS-1:0]   window_width;
      logic [SIZE_BITS-1:0]   window_height;
      logic [SIZE_BITS-1:0]   buffer_width;
      logic [SIZE_BITS-1:0]   buffer_height;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic                         rejected;
      logic signed [COORD_BITS-1:0] clipped_start_x;
      logic signed [COORD_BITS-1:0] clipped_start_y;
      logic signed [COORD_BITS-1:0] clipped_end_x;
      logic signed [COORD_BITS-1:0] clipped_end_y;
   } rsp_type;

   // Per-segment data that travels beside the ratio lanes.
   typedef struct packed {
      logic                  rej;
      logic [COORD_BITS-1:0] x0;
      logic [COORD_BITS-1:0] y0;
      logic [DELTA_BITS-1:0] dx;
      logic [DELTA_BITS-1:0] dy;
   } seg_type;

   typedef struct packed {
      logic [DELTA_BITS-1:0] p;
      logic [EDGE_BITS-1:0]  q;
   } edge_type;

   typedef struct packed {
      logic                skip;
      logic                neg;
      logic                zero;
      logic                sat;
      logic [MAG_BITS-1:0] ap;
      logic [REM_BITS-1:0] rem;
      logic [QUO_BITS-1:0] quo;
   } lane_type;

   typedef struct packed {
      logic              skip;
      logic              neg;
      logic [T_BITS-1:0] r;
   } ratio_type;

   function automatic logic [EDGE_BITS-1:0] sext_edge(input logic [COORD_BITS-1:0] v);
      return {{(EDGE_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
   endfunction

   function automatic logic [EDGE_BITS-1:0] zext_size(input logic [SIZE_BITS-1:0] v);
      return {{(EDGE_BITS-SIZE_BITS){1'b0}}, v};
   endfunction

endpackage

>>> rtl/line_segment_clipper_unit.sv
// Top level of the line segment clipper: configuration registers and pipeline.
//
// Clips one segment per transfer on the req_ channel against a rectangle and
// returns one transfer on the rsp_ channel: either a reject flag with zeroed
// endpoints, or the clipped endpoints. The rectangle is the configured window
// (use_window = 1) or the frame buffer bounds (use_window = 0), written through
// the csr_ port by register index; write it only while the pipeline is empty.
//
// An accepted request passes one setup stage, one sign stage and seventeen
// quotient-bit stages of the four parallel edge dividers, then parameter
// select, multiply and round stages. Throughput is one segment per cycle
// unless the receiver stalls; the divider depth sets the latency.
//
// When the receiver stalls a valid response, the whole pipeline holds and
// req_stall is raised in the same cycle, so nothing is lost or repeated.
// Reset empties the pipeline and sets every configuration register to zero.
module line_segment_clipper_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lbc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lbc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [lbc_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [lbc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   lbc_pkg::cfg_type   cfg_ff, cfg_in;
   logic               adv;
   logic               setup_vld, ratio_vld;
   lbc_pkg::seg_type   setup_seg, ratio_seg;
   lbc_pkg::edge_type  setup_edge [lbc_pkg::NUM_EDGES];
   lbc_pkg::ratio_type ratio_out [lbc_pkg::NUM_EDGES];

   // The pipeline moves whenever the output register is free or being drained.
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (lbc_pkg::csr_reg_type'(csr_addr))
            lbc_pkg::REG_USE_WINDOW:    cfg_in.use_window    = csr_wdata[0];
            lbc_pkg::REG_WINDOW_LEFT:   cfg_in.window_left   = csr_wdata;
            lbc_pkg::REG_WINDOW_TOP:    cfg_in.window_top    = csr_wdata;
            lbc_pkg::REG_WINDOW_WIDTH:
               cfg_in.window_width  = csr_wdata[lbc_pkg::SIZE_BITS-1:0];
            lbc_pkg::REG_WINDOW_HEIGHT:
               cfg_in.window_height = csr_wdata[lbc_pkg::SIZE_BITS-1:0];
            lbc_pkg::REG_BUFFER_WIDTH:
               cfg_in.buffer_width  = csr_wdata[lbc_pkg::SIZE_BITS-1:0];
            lbc_pkg::REG_BUFFER_HEIGHT:
               cfg_in.buffer_height = csr_wdata[lbc_pkg::SIZE_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lbc_setup u_setup (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (req_valid),
      .in_data  (req_data),
      .cfg      (cfg_ff),
      .out_vld  (setup_vld),
      .out_seg  (setup_seg),
      .out_edge (setup_edge)
   );

   lbc_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_vld    (setup_vld),
      .in_seg    (setup_seg),
      .in_edge   (setup_edge),
      .out_vld   (ratio_vld),
      .out_seg   (ratio_seg),
      .out_ratio (ratio_out)
   );

   lbc_finish u_finish (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (ratio_vld),
      .in_seg   (ratio_seg),
      .in_ratio (ratio_out),
      .out_vld  (rsp_valid),
      .out_data (rsp_data)
   );

   a_rej_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rejected |->
         rsp_data.clipped_start_x == '0 && rsp_data.clipped_start_y == '0 &&
         rsp_data.clipped_end_x == '0 && rsp_data.clipped_end_y == '0)
      else $error("rejected response carries nonzero endpoints");

   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow the output register state");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_addr > lbc_pkg::CSR_ADDR_BITS'(lbc_pkg::REG_BUFFER_HEIGHT)
         |=> $stable(cfg_ff))
      else $error("write to unknown register changed configuration");

endmodule

>>> rtl/lbc_setup.sv
// Input stage: window bounds, early reject, deltas and the left, top, right and bottom edge terms.
module lbc_setup (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_vld,
   input  lbc_pkg::req_type      in_data,
   input  lbc_pkg::cfg_type      cfg,
   output logic                  out_vld,
   output lbc_pkg::seg_type      out_seg,
   output lbc_pkg::edge_type     out_edge [lbc_pkg::NUM_EDGES]
);

   logic signed [lbc_pkg::EDGE_BITS-1:0] x0, y0, x1, y1, lx, ty, rx, by, dx, dy;
   logic signed [lbc_pkg::EDGE_BITS-1:0] ndx, ndy, q_left, q_top, q_right, q_bottom;
   logic                                 early_rej;

   logic                                 vld_ff;
   lbc_pkg::seg_type                     seg_ff, seg_in;
   lbc_pkg::edge_type                    edge_ff [lbc_pkg::NUM_EDGES];
   lbc_pkg::edge_type                    edge_in [lbc_pkg::NUM_EDGES];

   always_comb begin
      x0 = lbc_pkg::sext_edge(in_data.start_x);
      y0 = lbc_pkg::sext_edge(in_data.start_y);
      x1 = lbc_pkg::sext_edge(in_data.end_x);
      y1 = lbc_pkg::sext_edge(in_data.end_y);
      if (cfg.use_window) begin
         lx = lbc_pkg::sext_edge(cfg.window_left);
         ty = lbc_pkg::sext_edge(cfg.window_top);
         rx = lx + lbc_pkg::zext_size(cfg.window_width);
         by = ty + lbc_pkg::zext_size(cfg.window_height);
      end else begin
         lx = '0;
         ty = '0;
         rx = lbc_pkg::zext_size(cfg.buffer_width);
         by = lbc_pkg::zext_size(cfg.buffer_height);
      end
      early_rej = (x0 <= lx && x1 <= lx) || (x0 >= rx && x1 >= rx) ||
                  (y0 <= ty && y1 <= ty) || (y0 >= by && y1 >= by);
      dx       = x1 - x0;
      dy       = y1 - y0;
      ndx      = x0 - x1;
      ndy      = y0 - y1;
      q_left   = x0 - lx;
      q_top    = y0 - ty;
      q_right  = rx - x0;
      q_bottom = by - y0;

      seg_in.rej = early_rej;
      seg_in.x0  = in_data.start_x;
      seg_in.y0  = in_data.start_y;
      seg_in.dx  = dx[lbc_pkg::DELTA_BITS-1:0];
      seg_in.dy  = dy[lbc_pkg::DELTA_BITS-1:0];

      edge_in[0].p = ndx[lbc_pkg::DELTA_BITS-1:0];
      edge_in[0].q = q_left;
      edge_in[1].p = ndy[lbc_pkg::DELTA_BITS-1:0];
      edge_in[1].q = q_top;
      edge_in[2].p = dx[lbc_pkg::DELTA_BITS-1:0];
      edge_in[2].q = q_right;
      edge_in[3].p = dy[lbc_pkg::DELTA_BITS-1:0];
      edge_in[3].q = q_bottom;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_vld;
      end
      if (adv) begin
         seg_ff  <= seg_in;
         edge_ff <= edge_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_seg  = seg_ff;
   assign out_edge = edge_ff;

endmodule

>>> rtl/lbc_ratio.sv
// Pipelined edge ratio dividers: four lanes, one quotient bit per stage.
module lbc_ratio (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_vld,
   input  lbc_pkg::seg_type      in_seg,
   input  lbc_pkg::edge_type     in_edge [lbc_pkg::NUM_EDGES],
   output logic                  out_vld,
   output lbc_pkg::seg_type      out_seg,
   output lbc_pkg::ratio_type    out_ratio [lbc_pkg::NUM_EDGES]
);

   localparam int STAGES = lbc_pkg::QUO_BITS + 1;

   logic             vld_ff [STAGES];
   logic             vld_in [STAGES];
   lbc_pkg::seg_type seg_ff [STAGES];
   lbc_pkg::seg_type seg_in [STAGES];
   lbc_pkg::lane_type lane_ff [STAGES][lbc_pkg::NUM_EDGES];
   lbc_pkg::lane_type lane_in [STAGES][lbc_pkg::NUM_EDGES];

   logic signed [lbc_pkg::DELTA_BITS-1:0] p_s, p_abs;
   logic signed [lbc_pkg::EDGE_BITS-1:0]  q_s, q_abs;
   logic [lbc_pkg::REM_BITS-1:0]          ap_ext, diff;
   logic                                  ge;

   always_comb begin
      // First stage sorts out the signs and the saturated and zero cases.
      vld_in[0] = in_vld;
      seg_in[0] = in_seg;
      for (int e = 0; e < lbc_pkg::NUM_EDGES; e++) begin
         p_s   = in_edge[e].p;
         q_s   = in_edge[e].q;
         p_abs = (p_s < 0) ? -p_s : p_s;
         q_abs = (q_s < 0) ? -q_s : q_s;
         lane_in[0][e].skip = (p_s == 0);
         lane_in[0][e].neg  = (p_s < 0);
         lane_in[0][e].zero = (q_s == 0) || ((q_s < 0) != (p_s < 0));
         lane_in[0][e].ap   = p_abs[lbc_pkg::MAG_BITS-1:0];
         lane_in[0][e].rem  = q_abs[lbc_pkg::REM_BITS-1:0];
         lane_in[0][e].sat  = {1'b0, q_abs[lbc_pkg::REM_BITS-1:0]} >=
                              {1'b0, p_abs[lbc_pkg::MAG_BITS-1:0], 1'b0};
         lane_in[0][e].quo  = '0;
      end
      // Each later stage works out one quotient bit, most significant first.
      for (int s = 1; s < STAGES; s++) begin
         vld_in[s] = vld_ff[s-1];
         seg_in[s] = seg_ff[s-1];
         for (int e = 0; e < lbc_pkg::NUM_EDGES; e++) begin
            ap_ext = {1'b0, lane_ff[s-1][e].ap};
            ge     = lane_ff[s-1][e].rem >= ap_ext;
            diff   = ge ? (lane_ff[s-1][e].rem - ap_ext) : lane_ff[s-1][e].rem;
            lane_in[s][e]     = lane_ff[s-1][e];
            lane_in[s][e].rem = {diff[lbc_pkg::REM_BITS-2:0], 1'b0};
            lane_in[s][e].quo = {lane_ff[s-1][e].quo[lbc_pkg::QUO_BITS-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff <= vld_in;
      end
      if (adv) begin
         seg_ff  <= seg_in;
         lane_ff <= lane_in;
      end
   end

   always_comb begin
      for (int e = 0; e < lbc_pkg::NUM_EDGES; e++) begin
         out_ratio[e].skip = lane_ff[STAGES-1][e].skip;
         out_ratio[e].neg  = lane_ff[STAGES-1][e].neg;
         if (lane_ff[STAGES-1][e].zero) begin
            out_ratio[e].r = '0;
         end else if (lane_ff[STAGES-1][e].sat) begin
            out_ratio[e].r = lbc_pkg::T_TWO;
         end else begin
            out_ratio[e].r = {1'b0, lane_ff[STAGES-1][e].quo};
         end
      end
   end

   assign out_vld = vld_ff[STAGES-1];
   assign out_seg = seg_ff[STAGES-1];

endmodule

>>> rtl/lbc_finish.sv
// Output stages: entry and exit parameters, endpoint products, rounding.
module lbc_finish (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_vld,
   input  lbc_pkg::seg_type      in_seg,
   input  lbc_pkg::ratio_type    in_ratio [lbc_pkg::NUM_EDGES],
   output logic                  out_vld,
   output lbc_pkg::rsp_type      out_data
);

   localparam logic signed [lbc_pkg::PROD_BITS-1:0] HALF =
      lbc_pkg::PROD_BITS'(64'd1 << (lbc_pkg::FRACTION_BITS - 1));

   // Stage one: parameter selection.
   logic [lbc_pkg::T_BITS-1:0] t0, t1;
   logic                       vld1_ff, rej1_ff;
   lbc_pkg::seg_type           seg1_ff;
   logic [lbc_pkg::T_BITS-1:0] t0_ff, t1_ff;

   // Stage two: products.
   logic signed [lbc_pkg::PROD_BITS-1:0] ts0, ts1, dxs, dys;
   logic signed [lbc_pkg::PROD_BITS-1:0] prod_in [4];
   logic signed [lbc_pkg::PROD_BITS-1:0] prod_ff [4];
   logic                                 vld2_ff, rej2_ff;
   logic [lbc_pkg::COORD_BITS-1:0]       x0_ff, y0_ff;

   // Stage three: rounding and the result register.
   logic signed [lbc_pkg::PROD_BITS-1:0] rnd [4];
   logic [lbc_pkg::COORD_BITS-1:0]       pt [4];
   logic                                 rsp_vld_ff;
   lbc_pkg::rsp_type                     rsp_ff, rsp_in;

   always_comb begin
      t0 = '0;
      t1 = lbc_pkg::T_ONE;
      for (int e = 0; e < lbc_pkg::NUM_EDGES; e++) begin
         if (!in_ratio[e].skip) begin
            if (in_ratio[e].neg) begin
               if (in_ratio[e].r > t0) begin
                  t0 = in_ratio[e].r;
               end
            end else if (in_ratio[e].r < t1) begin
               t1 = in_ratio[e].r;
            end
         end
      end
   end

   always_comb begin
      ts0 = lbc_pkg::PROD_BITS'({1'b0, t0_ff});
      ts1 = lbc_pkg::PROD_BITS'({1'b0, t1_ff});
      dxs = {{(lbc_pkg::PROD_BITS-lbc_pkg::DELTA_BITS){seg1_ff.dx[lbc_pkg::DELTA_BITS-1]}},
             seg1_ff.dx};
      dys = {{(lbc_pkg::PROD_BITS-lbc_pkg::DELTA_BITS){seg1_ff.dy[lbc_pkg::DELTA_BITS-1]}},
             seg1_ff.dy};
      prod_in[0] = ts0 * dxs;
      prod_in[1] = ts0 * dys;
      prod_in[2] = ts1 * dxs;
      prod_in[3] = ts1 * dys;
   end

   always_comb begin
      // Arithmetic shift gives floor division, which is what rounding needs.
      for (int i = 0; i < 4; i++) begin
         rnd[i] = (prod_ff[i] + HALF) >>> lbc_pkg::FRACTION_BITS;
      end
      pt[0] = x0_ff + rnd[0][lbc_pkg::COORD_BITS-1:0];
      pt[1] = y0_ff + rnd[1][lbc_pkg::COORD_BITS-1:0];
      pt[2] = x0_ff + rnd[2][lbc_pkg::COORD_BITS-1:0];
      pt[3] = y0_ff + rnd[3][lbc_pkg::COORD_BITS-1:0];
      rsp_in.rejected = rej2_ff;
      if (rej2_ff) begin
         rsp_in.clipped_start_x = '0;
         rsp_in.clipped_start_y = '0;
         rsp_in.clipped_end_x   = '0;
         rsp_in.clipped_end_y   = '0;
      end else begin
         rsp_in.clipped_start_x = pt[0];
         rsp_in.clipped_start_y = pt[1];
         rsp_in.clipped_end_x   = pt[2];
         rsp_in.clipped_end_y   = pt[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff    <= in_vld;
         vld2_ff    <= vld1_ff;
         rsp_vld_ff <= vld2_ff;
      end
      if (adv) begin
         rej1_ff    <= in_seg.rej || (t0 > t1);
         seg1_ff    <= in_seg;
         t0_ff      <= t0;
         t1_ff      <= t1;
         rej2_ff    <= rej1_ff;
         x0_ff      <= seg1_ff.x0;
         y0_ff      <= seg1_ff.y0;
         prod_ff    <= prod_in;
         rsp_ff     <= rsp_in;
      end
   end

   assign out_vld  = rsp_vld_ff;
   assign out_data = rsp_ff;

endmodule

>>> bench/tb_line_segment_clipper_unit.sv
// Testbench of the line segment clipper: random and directed segments checked against a predictor.
`timescale 1ns / 1ps
module tb_line_segment_clipper_unit;

   localparam int LATENCY = 22;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lbc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lbc_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [lbc_pkg::CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [lbc_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   line_segment_clipper_unit u_top (.*);

   // Predictor copy of the configuration registers.
   logic        win_on;
   longint      win_left, win_top, win_w, win_h, buf_w, buf_h;

   lbc_pkg::req_type segment_queue[$];
   lbc_pkg::rsp_type clip_queue[$];
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   bit      hold_recv = 1'b0;
   int      hold_count = 0;
   longint  cycle_count = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic longint edge_ratio(longint q, longint p);
      longint r;
      if (q == 0 || ((q < 0) != (p < 0))) return 0;
      if (q < 0) q = -q;
      if (p < 0) p = -p;
      r = (q << lbc_pkg::FRACTION_BITS) / p;
      return (r > (2 << lbc_pkg::FRACTION_BITS)) ? (2 << lbc_pkg::FRACTION_BITS) : r;
   endfunction

   function automatic longint round_move(longint start, longint t, longint d);
      longint v;
      longint f;
      v = t * d + (1 << (lbc_pkg::FRACTION_BITS - 1));
      if (v >= 0) f = v >>> lbc_pkg::FRACTION_BITS;
      else f = -((-v + (1 << lbc_pkg::FRACTION_BITS) - 1) >>> lbc_pkg::FRACTION_BITS);
      return start + f;
   endfunction

   function automatic lbc_pkg::rsp_type clip_segment(lbc_pkg::req_type s);
      lbc_pkg::rsp_type r;
      longint x0, y0, x1, y1, lx, ty, rx, by, dx, dy, t0, t1, rt;
      longint pp[4];
      longint qq[4];
      x0 = s.start_x; y0 = s.start_y; x1 = s.end_x; y1 = s.end_y;
      if (win_on) begin
         lx = win_left; ty = win_top; rx = lx + win_w; by = ty + win_h;
      end else begin
         lx = 0; ty = 0; rx = buf_w; by = buf_h;
      end
      r = '0;
      r.rejected = 1'b1;
      if ((x0 <= lx && x1 <= lx) || (x0 >= rx && x1 >= rx) ||
          (y0 <= ty && y1 <= ty) || (y0 >= by && y1 >= by))
         return r;
      dx = x1 - x0; dy = y1 - y0;
      t0 = 0; t1 = 1 << lbc_pkg::FRACTION_BITS;
      pp = '{-dx, -dy, dx, dy};
      qq = '{x0 - lx, y0 - ty, rx - x0, by - y0};
      for (int i = 0; i < 4; i++) begin
         if (pp[i] != 0) begin
            rt = edge_ratio(qq[i], pp[i]);
            if (pp[i] < 0) begin
               if (rt > t0) t0 = rt;
            end else if (rt < t1) t1 = rt;
         end
      end
      if (t0 > t1) return r;
      r.rejected = 1'b0;
      r.clipped_start_x = 16'(round_move(x0, t0, dx));
      r.clipped_start_y = 16'(round_move(y0, t0, dy));
      r.clipped_end_x = 16'(round_move(x0, t1, dx));
      r.clipped_end_y = 16'(round_move(y0, t1, dy));
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // Driver: next queued segment goes out once the current transfer completes.
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (segment_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= segment_queue[0];
               req_valid <= 1'b1;
               clip_queue.push_back(clip_segment(segment_queue.pop_front()));
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor with random receiver stall and an optional long hold-off.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (clip_queue.size() == 0) begin
               $display("unexpected transfer at cycle %0d", cycle_count);
               error_count++;
            end else begin
               lbc_pkg::rsp_type w;
               w = clip_queue.pop_front();
               if (rsp_data.rejected !== w.rejected)
                  report_mismatch("rejected", rsp_data.rejected, w.rejected);
               if (rsp_data.clipped_start_x !== w.clipped_start_x)
                  report_mismatch("start_x", rsp_data.clipped_start_x, w.clipped_start_x);
               if (rsp_data.clipped_start_y !== w.clipped_start_y)
                  report_mismatch("start_y", rsp_data.clipped_start_y, w.clipped_start_y);
               if (rsp_data.clipped_end_x !== w.clipped_end_x)
                  report_mismatch("end_x", rsp_data.clipped_end_x, w.clipped_end_x);
               if (rsp_data.clipped_end_y !== w.clipped_end_y)
                  report_mismatch("end_y", rsp_data.clipped_end_y, w.clipped_end_y);
            end
         end
         if (hold_recv) begin
            hold_count <= hold_count + 1;
            rsp_stall <= (hold_count < 200);
         end else begin
            hold_count <= 0;
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   task automatic write_reg(lbc_pkg::csr_reg_type idx, longint value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= 16'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         lbc_pkg::REG_USE_WINDOW:    win_on = value[0];
         lbc_pkg::REG_WINDOW_LEFT:   win_left = longint'($signed(16'(value)));
         lbc_pkg::REG_WINDOW_TOP:    win_top = longint'($signed(16'(value)));
         lbc_pkg::REG_WINDOW_WIDTH:  win_w = value & 16'h7fff;
         lbc_pkg::REG_WINDOW_HEIGHT: win_h = value & 16'h7fff;
         lbc_pkg::REG_BUFFER_WIDTH:  buf_w = value & 16'h7fff;
         lbc_pkg::REG_BUFFER_HEIGHT: buf_h = value & 16'h7fff;
         default: ;
      endcase
   endtask

   task automatic configure(bit on, longint l, longint t, longint w, longint h,
                            longint bw, longint bh);
      write_reg(lbc_pkg::REG_USE_WINDOW, on);
      write_reg(lbc_pkg::REG_WINDOW_LEFT, l);
      write_reg(lbc_pkg::REG_WINDOW_TOP, t);
      write_reg(lbc_pkg::REG_WINDOW_WIDTH, w);
      write_reg(lbc_pkg::REG_WINDOW_HEIGHT, h);
      write_reg(lbc_pkg::REG_BUFFER_WIDTH, bw);
      write_reg(lbc_pkg::REG_BUFFER_HEIGHT, bh);
   endtask

   task automatic wait_drained();
      while (segment_queue.size() > 0 || clip_queue.size() > 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic add_segment(longint sx, longint sy, longint ex, longint ey);
      lbc_pkg::req_type s;
      s.start_x = 16'(sx); s.start_y = 16'(sy); s.end_x = 16'(ex); s.end_y = 16'(ey);
      segment_queue.push_back(s);
   endtask

   // Mostly coordinates near the clip rectangle so segments straddle its edges.
   function automatic longint near_coord(longint lo, longint hi);
      longint span;
      span = hi - lo + 64;
      if ($urandom_range(9) == 0) return longint'($signed(16'($urandom)));
      return lo - 32 + longint'($urandom_range(32'(span)));
   endfunction

   task automatic random_segments(int n);
      longint lo_x, lo_y, hi_x, hi_y;
      lo_x = win_on ? win_left : 0;
      lo_y = win_on ? win_top : 0;
      hi_x = lo_x + (win_on ? win_w : buf_w);
      hi_y = lo_y + (win_on ? win_h : buf_h);
      for (int i = 0; i < n; i++)
         add_segment(near_coord(lo_x, hi_x), near_coord(lo_y, hi_y),
                     near_coord(lo_x, hi_x), near_coord(lo_y, hi_y));
   endtask

   initial begin
      win_on = 0; win_left = 0; win_top = 0; win_w = 0; win_h = 0; buf_w = 0; buf_h = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset values: segments are clipped against an empty buffer.
      add_segment(-5, -5, 5, 5);
      add_segment(0, 0, 0, 0);
      wait_drained();

      configure(1'b1, -100, -50, 200, 100, 640, 480);
      add_segment(-32768, -32768, 32767, 32767);
      add_segment(32767, 32767, -32768, -32768);
      add_segment(-32768, 0, -32768, 10);
      add_segment(0, 0, 0, 0);
      add_segment(10, 10, 10, 10);
      add_segment(-100, -10, -100, 10);
      add_segment(100, -10, 100, 10);
      add_segment(-10, -50, 10, -50);
      add_segment(-10, 50, 10, 50);
      add_segment(-200, 0, 200, 0);
      add_segment(0, -200, 0, 200);
      add_segment(-300, -100, 300, 100);
      add_segment(-300, 200, 300, -200);
      add_segment(150, -100, 150, 100);
      add_segment(-150, 60, 150, 60);
      add_segment(-90, -40, 90, 40);
      add_segment(-101, 60, 101, -60);
      add_segment(-200, 60, 60, -200);
      add_segment(-32768, 32767, 32767, -32768);
      wait_drained();

      configure(1'b0, 32767, 32767, 32767, 32767, 32767, 32767);
      add_segment(-32768, -32768, 32767, 32767);
      add_segment(0, 32767, 32767, 0);
      random_segments(150);
      wait_drained();

      // Far window whose right and bottom edges pass the coordinate range.
      configure(1'b1, 32767, 32767, 32767, 32767, 0, 0);
      random_segments(100);
      wait_drained();

      configure(1'b1, -32768, -32768, 0, 0, 1, 1);
      random_segments(100);
      wait_drained();

      configure(1'b0, 0, 0, 0, 0, 320, 240);
      send_idle_pct = 82;
      random_segments(350);
      wait_drained();

      configure(1'b1, -20, 30, 50, 7, 1, 1);
      send_idle_pct = 0; recv_stall_pct = 82;
      random_segments(350);
      wait_drained();

      configure(1'b1, $urandom_range(400) - 200, $urandom_range(400) - 200,
                $urandom_range(300), $urandom_range(300), 100, 100);
      send_idle_pct = 19; recv_stall_pct = 19;
      random_segments(350);
      wait_drained();

      // Long receiver hold-off while the sender keeps offering segments.
      send_idle_pct = 0; recv_stall_pct = 0;
      hold_recv = 1'b1;
      random_segments(150);
      while (hold_count < 200) @(posedge clock);
      hold_recv = 1'b0;
      wait_drained();

      configure(1'b0, 0, 0, 0, 0, $urandom_range(32767), $urandom_range(32767));
      for (int i = 0; i < 350; i++)
         add_segment($signed(16'($urandom)), $signed(16'($urandom)),
                     $signed(16'($urandom)), $signed(16'($urandom)));
      wait_drained();

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
